// ===== sv/dcu_pkg.sv =====
// ----------------------------------------------------------------------------
// dcu_pkg: shared types and constants of the density column unit
// Register codes, payload structs, stage sideband and fixed-point constants.
// ----------------------------------------------------------------------------
package dcu_pkg;

   localparam int MAX_DEPTH = 64;
   // planes per column never exceed the plane index range
   localparam logic [6:0] DEPTH_CAP = (MAX_DEPTH < 64) ? 7'(MAX_DEPTH) : 7'd64;

   localparam logic [20:0] ARG_MAX   = 21'd1572864;         // 24.0 in Q16.16
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

   localparam logic [31:0] POW_HALF [8] = '{
      32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
      32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945
   };

   typedef enum logic [2:0] {
      REG_HEIGHT_GAIN   = 3'd0,
      REG_HEIGHT_OFFSET = 3'd1,
      REG_SIGMA_GAIN    = 3'd2,
      REG_SIGMA_OFFSET  = 3'd3,
      REG_SLOPE_FACTOR  = 3'd4,
      REG_FILL_DENSITY  = 3'd5,
      REG_DEPTH_IN_USE  = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      RCP_IDLE,
      RCP_RUN,
      RCP_DONE
   } rcp_state_type;

   typedef struct packed {
      logic signed [31:0] height_gain;
      logic signed [31:0] height_offset;
      logic signed [31:0] sigma_gain;
      logic signed [31:0] sigma_offset;
      logic signed [31:0] slope_factor;
      logic [15:0]        fill_density;
      logic [6:0]         depth_in_use;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] height_sample;
      logic signed [15:0] spread_sample;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] density_value;
      logic [5:0]  plane_index;
      logic        last_plane;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [31:0] center;
      logic signed [31:0] sigma;
   } map_result_type;

   typedef struct packed {
      logic signed [31:0] center;
      logic [31:0]        inv_sigma;   // Q8.24, zero selects step mode
   } rcp_result_type;

   typedef struct packed {
      logic [5:0] z;
      logic       last;
      logic       positive;
   } plane_type;

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (!v[48] && (|v[47:31])) begin
         r = 32'sh7FFF_FFFF;
      end else if (v[48] && !(&v[47:31])) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/dcu_map.sv =====
// ----------------------------------------------------------------------------
// dcu_map: linear height and spread mapping
// Two stages: gain products, then offset add with 32-bit saturation.
// ----------------------------------------------------------------------------
module dcu_map (
   input  logic                    clock,
   input  logic                    reset,
   input  dcu_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  dcu_pkg::req_payload_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dcu_pkg::map_result_type out_data
);
   import dcu_pkg::*;

   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic signed [47:0] hp_ff, hp_in, sp_ff, sp_in;
   map_result_type     res_ff, res_in;
   logic               en1, en2;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      v1_in  = en1 ? in_valid : v1_ff;
      hp_in  = en1 ? cfg.height_gain * in_data.height_sample : hp_ff;
      sp_in  = en1 ? cfg.sigma_gain * in_data.spread_sample : sp_ff;
      v2_in  = en2 ? v1_ff : v2_ff;
      res_in = res_ff;
      if (en2) begin
         res_in.center = sat32(49'(hp_ff) + 49'(cfg.height_offset));
         res_in.sigma  = sat32(49'(sp_ff) + 49'(cfg.sigma_offset));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      hp_ff  <= hp_in;
      sp_ff  <= sp_in;
      res_ff <= res_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = res_ff;

endmodule

// ===== sv/dcu_recip.sv =====
// ----------------------------------------------------------------------------
// dcu_recip: reciprocal of sigma
// Restoring divider, one quotient bit per cycle, round(2^40/sigma) in Q8.24.
// ----------------------------------------------------------------------------
module dcu_recip (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  dcu_pkg::map_result_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dcu_pkg::rcp_result_type out_data
);
   import dcu_pkg::*;

   rcp_state_type      state_ff, state_in;
   logic signed [31:0] center_ff, center_in;
   logic [30:0]        rem_ff, rem_in, div_ff, div_in;
   logic [31:0]        num_ff, num_in, quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        trial;
   logic               ge;

   always_comb begin
      state_in  = state_ff;
      center_in = center_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      trial     = {rem_ff, num_ff[31]};
      ge        = trial >= {1'b0, div_ff};
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         RCP_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               center_in = in_data.center;
               if (in_data.sigma[31] || in_data.sigma == 32'sd0) begin
                  quo_in   = '0;
                  state_in = RCP_DONE;
               end else if (in_data.sigma < 32'sd257) begin
                  // quotient reaches 2^32: saturate
                  quo_in   = '1;
                  state_in = RCP_DONE;
               end else begin
                  rem_in   = 31'd256;
                  num_in   = {1'b0, in_data.sigma[31:1]};   // low word of 2^40 + sigma/2
                  div_in   = in_data.sigma[30:0];
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = RCP_RUN;
               end
            end
         end
         RCP_RUN: begin
            rem_in = ge ? 31'(trial - {1'b0, div_ff}) : trial[30:0];
            num_in = {num_ff[30:0], 1'b0};
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == '1) begin
               state_in = RCP_DONE;
            end
         end
         RCP_DONE: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = RCP_IDLE;
            end
         end
         default: state_in = RCP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RCP_IDLE;
      end else begin
         state_ff <= state_in;
      end
      center_ff <= center_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
   end

   assign out_data.center    = center_ff;
   assign out_data.inv_sigma = quo_ff;

endmodule

// ===== sv/dcu_expo.sv =====
// ----------------------------------------------------------------------------
// dcu_expo: sigmoid argument and exp(-a) pipeline
// Fifteen stages: distance, products, clamp, log2 split, linear tail, eight power
// steps, final rounding shift.
// ----------------------------------------------------------------------------
module dcu_expo (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  dcu_pkg::cfg_type   cfg,
   input  logic               iss_valid,
   input  dcu_pkg::plane_type iss_info,
   input  logic signed [31:0] iss_center,
   input  logic [31:0]        iss_inv,
   output logic               out_valid,
   output logic [32:0]        out_e,
   output dcu_pkg::plane_type out_info
);
   import dcu_pkg::*;

   localparam int NSTAGE = 15;

   typedef struct packed {
      logic [32:0] e;
      logic [7:0]  fhi;
      logic [5:0]  k;
      plane_type   info;
   } exp_stage_type;

   logic [NSTAGE-1:0] vld_ff, vld_in;

   // stage 1
   logic [31:0] s1_dmag_ff, s1_dmag_in, s1_inv_ff, s1_inv_in;
   logic        s1_zero_ff, s1_zero_in, s1_step_ff, s1_step_in;
   plane_type   s1_info_ff, s1_info_in;
   // stage 2
   logic [46:0] s2_p16_ff, s2_p16_in;
   logic [31:0] s2_inv_ff, s2_inv_in;
   logic        s2_zero_ff, s2_zero_in, s2_step_ff, s2_step_in;
   plane_type   s2_info_ff, s2_info_in;
   // stage 3
   logic [62:0] s3_hp_ff, s3_hp_in;
   logic [47:0] s3_lp_ff, s3_lp_in;
   logic        s3_zero_ff, s3_zero_in, s3_step_ff, s3_step_in;
   plane_type   s3_info_ff, s3_info_in;
   // stage 4
   logic [20:0] s4_a_ff, s4_a_in;
   plane_type   s4_info_ff, s4_info_in;
   // stage 5
   logic [31:0] s5_f_ff, s5_f_in;
   logic [5:0]  s5_k_ff, s5_k_in;
   plane_type   s5_info_ff, s5_info_in;
   // stages 6 to 14
   exp_stage_type es_ff [9];
   exp_stage_type es_in [9];
   // stage 15
   logic [32:0] s15_e_ff, s15_e_in;
   plane_type   s15_info_ff, s15_info_in;

   logic signed [33:0] diff;
   logic signed [31:0] dsat;
   logic [31:0]        fmag;
   logic               fpos, fneg, dpos, dneg;
   logic [63:0]        prod;
   logic [78:0]        arg_sum;
   logic [54:0]        arg_raw;
   logic [51:0]        ylog;
   logic [55:0]        rln;
   logic [33:0]        rnd;

   assign vld_in = en ? {vld_ff[NSTAGE-2:0], iss_valid} : vld_ff;

   assign fmag = cfg.slope_factor[31] ? 32'(~cfg.slope_factor + 32'sd1)
                                      : 32'(cfg.slope_factor);
   assign fpos = !cfg.slope_factor[31] && cfg.slope_factor != 32'sd0;
   assign fneg = cfg.slope_factor[31];

   always_comb begin
      // distance to the surface, Q16.16 saturated
      diff = $signed({12'b0, iss_info.z, 16'b0}) - 34'(iss_center);
      if (!diff[33] && (|diff[32:31])) begin
         dsat = 32'sh7FFF_FFFF;
      end else if (diff[33] && !(&diff[32:31])) begin
         dsat = 32'sh8000_0000;
      end else begin
         dsat = diff[31:0];
      end
      dpos = !dsat[31] && dsat != 32'sd0;
      dneg = dsat[31];
      s1_dmag_in          = dsat[31] ? 32'(~dsat + 32'sd1) : 32'(dsat);
      s1_inv_in           = iss_inv;
      s1_zero_in          = !fpos && !fneg || !dpos && !dneg;
      s1_step_in          = iss_inv == '0;
      s1_info_in          = iss_info;
      s1_info_in.positive = fpos && dpos || fneg && dneg;

      prod       = 64'(fmag) * 64'(s1_dmag_ff);
      s2_p16_in  = prod[62:16];
      s2_inv_in  = s1_inv_ff;
      s2_zero_in = s1_zero_ff;
      s2_step_in = s1_step_ff;
      s2_info_in = s1_info_ff;

      s3_hp_in   = 63'(s2_p16_ff[46:16]) * 63'(s2_inv_ff);
      s3_lp_in   = 48'(s2_p16_ff[15:0]) * 48'(s2_inv_ff);
      s3_zero_in = s2_zero_ff;
      s3_step_in = s2_step_ff;
      s3_info_in = s2_info_ff;

      arg_sum = {s3_hp_ff, 16'b0} + 79'(s3_lp_ff);
      arg_raw = arg_sum[78:24];
      if (s3_step_ff) begin
         s4_a_in = s3_zero_ff ? '0 : ARG_MAX;
      end else begin
         s4_a_in = (arg_raw > 55'(ARG_MAX)) ? ARG_MAX : arg_raw[20:0];
      end
      s4_info_in = s3_info_ff;

      ylog       = 52'(s4_a_ff) * 52'(LOG2E_Q30);
      s5_k_in    = ylog[51:46];
      s5_f_in    = ylog[45:14];
      s5_info_in = s4_info_ff;

      // linear tail of the fraction
      rln          = 56'(s5_f_ff[23:0]) * 56'(LN2_Q32);
      es_in[0].e    = ONE_Q32 - 33'(rln[55:32]);
      es_in[0].fhi  = s5_f_ff[31:24];
      es_in[0].k    = s5_k_ff;
      es_in[0].info = s5_info_ff;

      rnd = 34'(es_ff[8].e);
      if (es_ff[8].k != '0) begin
         rnd = (rnd + (34'd1 << (es_ff[8].k - 6'd1))) >> es_ff[8].k;
      end
      s15_e_in    = rnd[32:0];
      s15_info_in = es_ff[8].info;
   end

   // power steps: 2^(-2^-(i+1)) for each set top fraction bit
   for (genvar i = 0; i < 8; i++) begin : g_pow
      logic [64:0] mp;
      always_comb begin
         mp = 65'(es_ff[i].e) * 65'(POW_HALF[i]) + 65'h8000_0000;
         es_in[i+1]   = es_ff[i];
         if (es_ff[i].fhi[7-i]) begin
            es_in[i+1].e = mp[64:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (en) begin
         s1_dmag_ff  <= s1_dmag_in;
         s1_inv_ff   <= s1_inv_in;
         s1_zero_ff  <= s1_zero_in;
         s1_step_ff  <= s1_step_in;
         s1_info_ff  <= s1_info_in;
         s2_p16_ff   <= s2_p16_in;
         s2_inv_ff   <= s2_inv_in;
         s2_zero_ff  <= s2_zero_in;
         s2_step_ff  <= s2_step_in;
         s2_info_ff  <= s2_info_in;
         s3_hp_ff    <= s3_hp_in;
         s3_lp_ff    <= s3_lp_in;
         s3_zero_ff  <= s3_zero_in;
         s3_step_ff  <= s3_step_in;
         s3_info_ff  <= s3_info_in;
         s4_a_ff     <= s4_a_in;
         s4_info_ff  <= s4_info_in;
         s5_f_ff     <= s5_f_in;
         s5_k_ff     <= s5_k_in;
         s5_info_ff  <= s5_info_in;
         es_ff       <= es_in;
         s15_e_ff    <= s15_e_in;
         s15_info_ff <= s15_info_in;
      end
   end

   assign out_valid = vld_ff[NSTAGE-1];
   assign out_e     = s15_e_ff;
   assign out_info  = s15_info_ff;

endmodule

// ===== sv/dcu_quot.sv =====
// ----------------------------------------------------------------------------
// dcu_quot: density quotient pipeline
// round(D*num/(1+e)) by a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dcu_quot (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  dcu_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   input  logic [32:0]              in_e,
   input  dcu_pkg::plane_type       in_info,
   output logic                     out_valid,
   output dcu_pkg::rsp_payload_type out_data
);
   import dcu_pkg::*;

   localparam int QBITS = 16;

   typedef struct packed {
      logic [32:0] rem;
      logic [15:0] xlo;
      logic [15:0] q;
      logic [33:0] den;
      plane_type   info;
   } q_stage_type;

   logic [QBITS:0] vld_ff, vld_in;
   q_stage_type    qs_ff [QBITS+1];
   q_stage_type    qs_in [QBITS+1];
   logic [33:0]    den;
   logic [32:0]    num;
   logic [48:0]    xnum;

   assign vld_in = en ? {vld_ff[QBITS-1:0], in_valid} : vld_ff;

   always_comb begin
      den  = 34'(ONE_Q32) + 34'(in_e);
      num  = in_info.positive ? in_e : ONE_Q32;
      xnum = 49'(cfg.fill_density) * 49'(num) + 49'(den[33:1]);
      qs_in[0].rem  = xnum[48:16];
      qs_in[0].xlo  = xnum[15:0];
      qs_in[0].q    = '0;
      qs_in[0].den  = den;
      qs_in[0].info = in_info;
   end

   for (genvar j = 1; j <= QBITS; j++) begin : g_div
      logic [33:0] trial;
      logic        ge;
      always_comb begin
         trial         = {qs_ff[j-1].rem, qs_ff[j-1].xlo[15]};
         ge            = trial >= qs_ff[j-1].den;
         qs_in[j]      = qs_ff[j-1];
         qs_in[j].rem  = ge ? 33'(trial - qs_ff[j-1].den) : trial[32:0];
         qs_in[j].xlo  = {qs_ff[j-1].xlo[14:0], 1'b0};
         qs_in[j].q    = {qs_ff[j-1].q[14:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (en) begin
         qs_ff <= qs_in;
      end
   end

   assign out_valid              = vld_ff[QBITS];
   assign out_data.density_value = qs_ff[QBITS].q;
   assign out_data.plane_index   = qs_ff[QBITS].info.z;
   assign out_data.last_plane    = qs_ff[QBITS].info.last;

endmodule

// ===== sv/height_to_sigmoid_density_column_unit.sv =====
// ----------------------------------------------------------------------------
// height_to_sigmoid_density_column_unit: sigmoid density column from a height
// One pixel beat in, one voxel beat out per z plane, last plane marked.
// ----------------------------------------------------------------------------
// Each accepted pixel yields min(depth_in_use, 64) voxel beats, one per cycle
// while rsp_ready holds. The sigma reciprocal comes from a 32-step restoring
// divider that runs on the next pixel while the current column streams, so
// columns of 34 or more planes follow back to back. Non-positive or tiny
// sigma skips the divider. Before its first voxel beat a pixel passes the 2
// mapping stages, the divider, the sequencer, the 15 exp stages and the 17
// quotient stages.
// Configuration must be written while idle; no clearing pass after reset.
// ----------------------------------------------------------------------------
module height_to_sigmoid_density_column_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dcu_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dcu_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata
);
   import dcu_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // mapping -> divider -> column sequencer
   logic           map_valid, map_ready;
   map_result_type map_data;
   logic           rcp_valid, rcp_ready;
   rcp_result_type rcp_data;

   // column sequencer state
   logic               col_active_ff, col_active_in;
   logic [5:0]         col_z_ff, col_z_in;
   logic [6:0]         col_count_ff, col_count_in;
   logic signed [31:0] col_center_ff, col_center_in;
   logic [31:0]        col_inv_ff, col_inv_in;

   logic       en;           // voxel pipeline advances
   logic       issue, at_last, issue_last, rcp_load;
   logic [6:0] planes;
   plane_type  iss_info;

   logic        exp_valid;
   logic [32:0] exp_e;
   plane_type   exp_info;

   // register file: plain writes, unknown index dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_HEIGHT_GAIN:   cfg_in.height_gain   = csr_wdata;
            REG_HEIGHT_OFFSET: cfg_in.height_offset = csr_wdata;
            REG_SIGMA_GAIN:    cfg_in.sigma_gain    = csr_wdata;
            REG_SIGMA_OFFSET:  cfg_in.sigma_offset  = csr_wdata;
            REG_SLOPE_FACTOR:  cfg_in.slope_factor  = csr_wdata;
            REG_FILL_DENSITY:  cfg_in.fill_density  = csr_wdata[15:0];
            REG_DEPTH_IN_USE:  cfg_in.depth_in_use  = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   dcu_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_data  (map_data)
   );

   dcu_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (map_valid),
      .in_ready  (map_ready),
      .in_data   (map_data),
      .out_valid (rcp_valid),
      .out_ready (rcp_ready),
      .out_data  (rcp_data)
   );

   // whole voxel pipeline stalls together behind the output register
   assign en = !rsp_valid || rsp_ready;

   // column sequencer: one plane per advancing cycle
   assign planes     = (cfg_ff.depth_in_use > DEPTH_CAP) ? DEPTH_CAP : cfg_ff.depth_in_use;
   assign issue      = col_active_ff && en;
   assign at_last    = (7'(col_z_ff) + 7'd1) == col_count_ff;
   assign issue_last = issue && at_last;
   // next column loads when idle or as the current one issues its last plane
   assign rcp_ready  = !col_active_ff || issue_last;
   assign rcp_load   = rcp_valid && rcp_ready;

   always_comb begin
      col_active_in = col_active_ff;
      col_z_in      = col_z_ff;
      col_count_in  = col_count_ff;
      col_center_in = col_center_ff;
      col_inv_in    = col_inv_ff;
      if (rcp_load) begin
         col_active_in = planes != '0;   // empty column: nothing to emit
         col_z_in      = '0;
         col_count_in  = planes;
         col_center_in = rcp_data.center;
         col_inv_in    = rcp_data.inv_sigma;
      end else if (issue_last) begin
         col_active_in = 1'b0;
      end else if (issue) begin
         col_z_in = col_z_ff + 6'd1;
      end
   end

   assign iss_info.z        = col_z_ff;
   assign iss_info.last     = at_last;
   assign iss_info.positive = 1'b0;      // set in the distance stage

   dcu_expo u_expo (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg_ff),
      .iss_valid  (issue),
      .iss_info   (iss_info),
      .iss_center (col_center_ff),
      .iss_inv    (col_inv_ff),
      .out_valid  (exp_valid),
      .out_e      (exp_e),
      .out_info   (exp_info)
   );

   dcu_quot u_quot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (exp_valid),
      .in_e      (exp_e),
      .in_info   (exp_info),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.height_gain   <= 32'sd65536;
         cfg_ff.height_offset <= 32'sd0;
         cfg_ff.sigma_gain    <= 32'sd0;
         cfg_ff.sigma_offset  <= 32'sd65536;
         cfg_ff.slope_factor  <= 32'sd106040;
         cfg_ff.fill_density  <= 16'd256;
         cfg_ff.depth_in_use  <= 7'd64;
         col_active_ff        <= 1'b0;
         col_z_ff             <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         col_active_ff <= col_active_in;
         col_z_ff      <= col_z_in;
      end
      col_count_ff  <= col_count_in;
      col_center_ff <= col_center_in;
      col_inv_ff    <= col_inv_in;
   end

`ifndef SYNTHESIS
   // plane counter stays inside the column
   a_z_in_range: assert property (@(posedge clock) disable iff (reset)
      col_active_ff |-> (7'(col_z_ff) < col_count_ff))
      else $error("plane counter past column end");

   // a column with no successor goes idle after its last plane
   a_col_ends: assert property (@(posedge clock) disable iff (reset)
      (issue_last && !rcp_load) |=> !col_active_ff)
      else $error("column still active after last plane");

   // planes step by one inside a column
   a_z_step: assert property (@(posedge clock) disable iff (reset)
      (issue && !issue_last) |=> (col_z_ff == $past(col_z_ff) + 6'd1))
      else $error("plane counter skipped");
`endif

endmodule
